/* src/tks_pkg.sv */
// ----------------------------------------------------------------------------
// tks_pkg: shared definitions for the topological sort block
// Sizes of the graph store, action codes and the result hand-off record.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VID_W        = 4;                          // vertex field width
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);   // holds 0..MAX_VERTICES

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_EDGE  = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    // One result handed from the sequencer to the output register.
    typedef struct packed {
        logic             load;
        logic [VID_W-1:0] vertex;
        logic             vertex_valid;
        logic             cycle_found;
        logic             last;
    } emit_t;

endpackage

/* src/topological_sort_kahn.sv */
// ----------------------------------------------------------------------------
// topological_sort_kahn: Kahn topological sort over an adjacency bit matrix
// Stream in clear, edge and run commands; stream out the sorted vertices.
// ----------------------------------------------------------------------------
// Usage: write vertex_count (values above 16 act as 16), then send beats with
// tuser selecting the action: clear the graph, add the edge from_vertex ->
// to_vertex (ignored if either end is at or above the vertex count), or run
// the sort. Clear and edge beats give no output. A run counts the in-degrees,
// seeds the queue with the vertices of in-degree zero, releases the successors
// of each sorted vertex, then finds the queue empty and hands over the final
// beat; it waits whenever the output side stalls. A single in-degree adder
// handles one matrix bit per cycle. The input is not ready during a run.
// Vertices come out in sorted order; the final beat of a run has tlast set
// and reports in tuser whether a cycle left vertices unsorted. A run that
// sorts nothing gives one beat with vertex_valid clear. The graph is cleared
// by reset.
// ----------------------------------------------------------------------------
module topological_sort_kahn (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: vertex_count.
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [3:0] from_vertex, [7:4] to_vertex
    input  logic [1:0]  s_tuser,    // [1:0] action
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [3:0] vertex, [7:4] zero
    output logic [1:0]  m_tuser,    // [0] vertex_valid, [1] cycle_found
    output logic        m_tlast     // last
);
    import tks_pkg::*;

    logic [4:0]              vertex_count_reg;
    logic [CNT_W-1:0]        n;
    logic                    accept, busy, slot_free;
    logic [VID_W-1:0]        from_vertex, to_vertex, rd_row;
    logic [MAX_VERTICES-1:0] adj_row;
    emit_t                   emit;

    logic                    m_tvalid_reg;
    logic [VID_W-1:0]        vertex_reg;
    logic                    vertex_valid_reg, cycle_found_reg, last_reg;

    // The user must write the count register only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
        end else if (cfg_wr_en) begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    // Active vertex count, saturated to the matrix size.
    assign n = (CNT_W'(vertex_count_reg) > CNT_W'(MAX_VERTICES)) ?
               CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count_reg);

    assign from_vertex = s_tdata[3:0];
    assign to_vertex   = s_tdata[7:4];
    assign s_tready    = !busy;
    assign accept      = s_tvalid && s_tready;

    tks_adj_mem u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (accept && s_tuser == ACT_CLEAR),
        .set_en  (accept && s_tuser == ACT_EDGE &&
                  {1'b0, from_vertex} < n && {1'b0, to_vertex} < n),
        .set_row (from_vertex),
        .set_col (to_vertex),
        .rd_row  (rd_row),
        .rd_data (adj_row)
    );

    // The output register frees up in the cycle its beat is taken, so the
    // sequencer never waits more than the consumer makes it.
    assign slot_free = !m_tvalid_reg || m_tready;

    tks_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .run_start (accept && s_tuser == ACT_RUN),
        .n         (n),
        .slot_free (slot_free),
        .adj_row   (adj_row),
        .rd_row    (rd_row),
        .busy      (busy),
        .emit      (emit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (emit.load) begin
            vertex_reg       <= emit.vertex;
            vertex_valid_reg <= emit.vertex_valid;
            cycle_found_reg  <= emit.cycle_found;
            last_reg         <= emit.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, vertex_reg};
    assign m_tuser  = {cycle_found_reg, vertex_valid_reg};
    assign m_tlast  = last_reg;

    // A run keeps the input not ready in the cycle after it is accepted.
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser == ACT_RUN |=> !s_tready)
        else $error("input ready right after a run was accepted");

    // Only the final beat of a run may carry an unsorted marker or a cycle.
    a_mid_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[0] && !m_tuser[1])
        else $error("non-final beat is not a plain sorted vertex");

    // A run that sorts nothing reports vertex zero.
    a_empty_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
        else $error("empty result beat malformed");

    // Clear and edge beats leave the sequencer idle.
    a_cmd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser != ACT_RUN |=> s_tready)
        else $error("sequencer left idle by a non-run beat");

endmodule

/* src/tks_adj_mem.sv */
// ----------------------------------------------------------------------------
// tks_adj_mem: adjacency bit matrix
// One row per source vertex, one bit per destination. Cleared at reset and
// by a clear item; an edge write sets a single bit; one row is read at a time.
// ----------------------------------------------------------------------------
module tks_adj_mem (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                clear,
    input  logic                                set_en,
    input  logic [tks_pkg::VID_W-1:0]           set_row,
    input  logic [tks_pkg::VID_W-1:0]           set_col,
    input  logic [tks_pkg::VID_W-1:0]           rd_row,
    output logic [tks_pkg::MAX_VERTICES-1:0]    rd_data
);
    import tks_pkg::*;

    logic [MAX_VERTICES-1:0] rows_reg [MAX_VERTICES];

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int r = 0; r < MAX_VERTICES; r++) begin
                rows_reg[r] <= '0;
            end
        end else if (set_en) begin
            rows_reg[set_row][set_col] <= 1'b1;
        end
    end

    assign rd_data = rows_reg[rd_row];

endmodule

/* src/tks_seq.sv */
// ----------------------------------------------------------------------------
// tks_seq: sort sequencer
// Walks the matrix one bit per cycle through a single in-degree adder, pausing
// on a full output register, keeps the ready queue, hands results one at a time.
// ----------------------------------------------------------------------------
module tks_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                run_start,
    input  logic [tks_pkg::CNT_W-1:0]           n,
    input  logic                                slot_free,
    input  logic [tks_pkg::MAX_VERTICES-1:0]    adj_row,
    output logic [tks_pkg::VID_W-1:0]           rd_row,
    output logic                                busy,
    output tks_pkg::emit_t                      emit
);
    import tks_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DEG, S_SEED, S_POP, S_SCAN, S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [VID_W-1:0]  u_reg, u_next;
    logic [VID_W-1:0]  v_reg, v_next;
    logic [VID_W-1:0]  pend_reg, pend_next;
    logic [CNT_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [CNT_W-1:0]  deg_mem   [MAX_VERTICES];
    logic [VID_W-1:0]  queue_mem [MAX_VERTICES];

    logic              deg_we, q_we;
    logic [CNT_W-1:0]  deg_rd, deg_a, deg_b, deg_sum;
    logic [VID_W-1:0]  q_rd, q_wdata;
    logic              row_bit, v_last, u_last, q_empty, q_room;

    assign deg_rd  = deg_mem[v_reg];
    assign q_rd    = queue_mem[head_reg[VID_W-1:0]];
    assign rd_row  = (state_reg == S_SCAN) ? pend_reg : u_reg;
    assign row_bit = adj_row[v_reg];
    assign v_last  = ({1'b0, v_reg} == n - CNT_W'(1));
    assign u_last  = ({1'b0, u_reg} == n - CNT_W'(1));
    assign q_empty = (head_reg == tail_reg);
    assign q_room  = (tail_reg < CNT_W'(MAX_VERTICES));
    assign busy    = (state_reg != S_IDLE);

    // The one shared adder: counts up while building in-degrees, down while
    // releasing successors.
    assign deg_a   = (state_reg == S_DEG && u_reg == '0) ? '0 : deg_rd;
    assign deg_b   = (state_reg == S_DEG) ? {{(CNT_W-1){1'b0}}, row_bit} : '1;
    assign deg_sum = deg_a + deg_b;

    always_comb begin
        state_next = state_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        pend_next  = pend_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        deg_we     = 1'b0;
        q_we       = 1'b0;
        q_wdata    = v_reg;
        emit       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (run_start) begin
                    u_next     = '0;
                    v_next     = '0;
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    state_next = S_DEG;
                end
            end
            S_DEG: begin
                if (n == '0) begin
                    state_next = S_POP;
                end else begin
                    deg_we = 1'b1;
                    if (v_last) begin
                        v_next = '0;
                        if (u_last) begin
                            state_next = S_SEED;
                        end else begin
                            u_next = u_reg + VID_W'(1);
                        end
                    end else begin
                        v_next = v_reg + VID_W'(1);
                    end
                end
            end
            S_SEED: begin
                if (deg_rd == '0 && q_room) begin
                    q_we      = 1'b1;
                    tail_next = tail_reg + CNT_W'(1);
                end
                if (v_last) begin
                    state_next = S_POP;
                end else begin
                    v_next = v_reg + VID_W'(1);
                end
            end
            S_POP: begin
                if (q_empty) begin
                    state_next = S_FIN;
                end else if (count_reg == '0 || slot_free) begin
                    // The previous vertex goes out now that another follows it.
                    emit.load         = (count_reg != '0);
                    emit.vertex       = pend_reg;
                    emit.vertex_valid = 1'b1;
                    pend_next         = q_rd;
                    head_next         = head_reg + CNT_W'(1);
                    count_next        = count_reg + CNT_W'(1);
                    v_next            = '0;
                    state_next        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (row_bit && deg_rd != '0) begin
                    deg_we = 1'b1;
                    if (deg_sum == '0 && q_room) begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + CNT_W'(1);
                    end
                end
                if (v_last) begin
                    state_next = S_POP;
                end else begin
                    v_next = v_reg + VID_W'(1);
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    emit.load = 1'b1;
                    emit.last = 1'b1;
                    if (count_reg == '0) begin
                        emit.vertex       = '0;
                        emit.vertex_valid = 1'b0;
                        emit.cycle_found  = (n != '0);
                    end else begin
                        emit.vertex       = pend_reg;
                        emit.vertex_valid = 1'b1;
                        emit.cycle_found  = (count_reg < n);
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
        u_reg    <= u_next;
        v_reg    <= v_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[v_reg] <= deg_sum;
        end
        if (q_we) begin
            queue_mem[tail_reg[VID_W-1:0]] <= q_wdata;
        end
    end

endmodule
